@@ sv/aes_pkg.sv @@
// aes_pkg: shared types, codes, substitution tables and helpers for the aes block cipher unit
// no dependencies

package aes_pkg;

	localparam int KEY_WORDS = 60;
	localparam int KEY_ROWS  = 15;

	localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
	localparam logic [2:0] CFG_KEY_WORD_0 = 3'd1;
	localparam logic [2:0] CFG_KEY_WORD_1 = 3'd2;
	localparam logic [2:0] CFG_KEY_WORD_2 = 3'd3;
	localparam logic [2:0] CFG_KEY_WORD_3 = 3'd4;

	localparam logic [1:0] KEY_LEN_128 = 2'd0;
	localparam logic [1:0] KEY_LEN_192 = 2'd1;
	localparam logic [1:0] KEY_LEN_256 = 2'd2;

	typedef struct packed {
		logic        action;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} aes_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_START,
		ST_ADDK,
		ST_RUN,
		ST_DONE
	} aes_state_t;

	typedef struct packed {
		logic       capture;
		logic       decrypt;
		logic       kx_step;
		logic [5:0] kidx;
		logic       add_key;
		logic       round;
		logic       last;
		logic [3:0] rd_row;
		logic       load_out;
	} aes_cmd_t;

	typedef logic [7:0] byte_tbl_t [256];

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = xtime(x);
		end
		return p;
	endfunction

	function automatic byte_tbl_t gen_sbox();
		byte_tbl_t  t;
		logic [7:0] r;
		logic [7:0] b;
		logic [7:0] e;
		for (int x = 0; x < 256; x++) begin
			r = 8'h01;
			b = 8'(x);
			e = 8'd254;
			for (int k = 0; k < 8; k++) begin
				if (e[k]) r = gf_mul(r, b);
				b = gf_mul(b, b);
			end
			t[x] = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
				^ {r[3:0], r[7:4]} ^ 8'h63;
		end
		return t;
	endfunction

	localparam byte_tbl_t SBOX = gen_sbox();

	function automatic byte_tbl_t gen_inv_sbox();
		byte_tbl_t t;
		for (int x = 0; x < 256; x++) begin
			t[SBOX[x]] = 8'(x);
		end
		return t;
	endfunction

	localparam byte_tbl_t INV_SBOX = gen_inv_sbox();

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [3:0] nk_of(input logic [1:0] klen);
		logic [3:0] n;
		unique case (klen)
			KEY_LEN_128: n = 4'd4;
			KEY_LEN_192: n = 4'd6;
			default:     n = 4'd8;
		endcase
		return n;
	endfunction

	function automatic logic [3:0] nr_of(input logic [1:0] klen);
		logic [3:0] n;
		unique case (klen)
			KEY_LEN_128: n = 4'd10;
			KEY_LEN_192: n = 4'd12;
			default:     n = 4'd14;
		endcase
		return n;
	endfunction

endpackage

@@ sv/aes_block_cipher_unit.sv @@
// aes_block_cipher_unit: top level of the aes ecb engine
// depends on aes_pkg, aes_key_exp, aes_round_dp, aes_ctrl

// AES-128/192/256 ECB engine. Load key_length (index 0) and key words (indexes 1 to 4)
// while idle; the first request after reset or after any register write first expands the
// key, one schedule word per cycle (44, 52 or 60 words), into a 15-row round key store.
// Each request is captured on acceptance, then passes through a start state, a key addition
// state and the rounds: one full round per cycle through a single round unit fed by the
// round key store, whose registered read makes the start state necessary. A finished result
// waits in an output register while the next request is accepted.

module aes_block_cipher_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  aes_pkg::aes_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output aes_pkg::aes_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);
	import aes_pkg::*;

	aes_cmd_t     cmd;
	logic [1:0]   klen;
	logic [127:0] round_key;
	logic         cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;

	aes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_action (in_data.action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_we),
		.klen      (klen),
		.cmd       (cmd)
	);

	aes_key_exp u_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.klen      (klen),
		.round_key (round_key)
	);

	aes_round_dp u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.in_data   (in_data),
		.round_key (round_key),
		.out_data  (out_data)
	);

endmodule

@@ sv/aes_key_exp.sv @@
// aes_key_exp: key registers, one-word-per-cycle key schedule and round key store
// depends on aes_pkg

module aes_key_exp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	input  aes_pkg::aes_cmd_t cmd,
	output logic [1:0]        klen,
	output logic [127:0]      round_key
);
	import aes_pkg::*;

	logic [1:0]   klen_q;
	logic [255:0] key_q;
	logic [31:0]  win_q [8];
	logic [2:0]   j_q;
	logic [7:0]   rc_q;
	logic [127:0] mem [KEY_ROWS];
	logic [127:0] rk_q;

	logic [31:0] kwords [8];
	logic [3:0]  nk;
	logic        is_key;
	logic [2:0]  j_cur;
	logic [7:0]  rc_cur;
	logic [31:0] far_w;
	logic [31:0] t;
	logic [31:0] w_new;

	assign klen = klen_q[1] ? KEY_LEN_256 : klen_q;
	assign nk   = nk_of(klen);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			kwords[i] = key_q[255 - 32 * i -: 32];
		end
	end

	always_comb begin
		is_key = cmd.kidx < {2'b00, nk};
		j_cur  = (cmd.kidx == 6'd0) ? 3'd0 : j_q;
		rc_cur = (cmd.kidx == 6'd0) ? 8'h01 : rc_q;
		unique case (klen)
			KEY_LEN_128: far_w = win_q[3];
			KEY_LEN_192: far_w = win_q[5];
			default:     far_w = win_q[7];
		endcase
		t = win_q[0];
		if (j_cur == 3'd0) begin
			t = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rc_cur, 24'h0};
		end else if (klen == KEY_LEN_256 && j_cur == 3'd4) begin
			t = sub_word(win_q[0]);
		end
		w_new = is_key ? kwords[cmd.kidx[2:0]] : (t ^ far_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= KEY_LEN_128;
			key_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_LENGTH: klen_q <= cfg_data[1:0];
				CFG_KEY_WORD_0: key_q[255:192] <= cfg_data;
				CFG_KEY_WORD_1: key_q[191:128] <= cfg_data;
				CFG_KEY_WORD_2: key_q[127:64] <= cfg_data;
				CFG_KEY_WORD_3: key_q[63:0] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.kx_step) begin
			win_q[0] <= w_new;
			for (int k = 1; k < 8; k++) begin
				win_q[k] <= win_q[k - 1];
			end
			j_q  <= (j_cur == 3'(nk - 4'd1)) ? 3'd0 : j_cur + 3'd1;
			rc_q <= (!is_key && j_cur == 3'd0) ? xtime(rc_cur) : rc_cur;
			if (cmd.kidx[1:0] == 2'b11) begin
				mem[cmd.kidx[5:2]] <= {win_q[2], win_q[1], win_q[0], w_new};
			end
		end
		rk_q <= mem[cmd.rd_row];
	end

	assign round_key = rk_q;

endmodule

@@ sv/aes_round_dp.sv @@
// aes_round_dp: cipher state register, one full round per cycle, result register
// depends on aes_pkg

module aes_round_dp (
	input  logic               clk,
	input  aes_pkg::aes_cmd_t  cmd,
	input  aes_pkg::aes_in_t   in_data,
	input  logic [127:0]       round_key,
	output aes_pkg::aes_out_t  out_data
);
	import aes_pkg::*;

	logic [127:0] st_q;
	logic [127:0] res_q;
	logic [127:0] nxt;

	function automatic logic [7:0] mulc(input logic [7:0] a, input int sel, input logic inv);
		logic [7:0] x2;
		logic [7:0] x4;
		logic [7:0] x8;
		logic [7:0] r;
		x2 = xtime(a);
		x4 = xtime(x2);
		x8 = xtime(x4);
		if (!inv) begin
			unique case (sel)
				0:       r = x2;
				1:       r = x2 ^ a;
				default: r = a;
			endcase
		end else begin
			unique case (sel)
				0:       r = x8 ^ x4 ^ x2;
				1:       r = x8 ^ x2 ^ a;
				2:       r = x8 ^ x4 ^ a;
				default: r = x8 ^ a;
			endcase
		end
		return r;
	endfunction

	always_comb begin
		logic [7:0] s  [16];
		logic [7:0] a  [16];
		logic [7:0] b  [16];
		logic [7:0] m  [16];
		logic [7:0] kb [16];
		for (int i = 0; i < 16; i++) begin
			s[i]  = st_q[127 - 8 * i -: 8];
			kb[i] = round_key[127 - 8 * i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (!cmd.decrypt) begin
					a[4 * c + r] = SBOX[s[4 * ((c + r) & 3) + r]];
				end else begin
					a[4 * c + r] = INV_SBOX[s[4 * ((c - r + 4) & 3) + r]] ^ kb[4 * c + r];
				end
			end
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				m[4 * c + r] = 8'h00;
				for (int k = 0; k < 4; k++) begin
					m[4 * c + r] = m[4 * c + r] ^ mulc(a[4 * c + k], (k - r + 4) & 3, cmd.decrypt);
				end
			end
		end
		for (int i = 0; i < 16; i++) begin
			if (!cmd.decrypt) begin
				b[i] = (cmd.last ? a[i] : m[i]) ^ kb[i];
			end else begin
				b[i] = cmd.last ? a[i] : m[i];
			end
			nxt[127 - 8 * i -: 8] = b[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			st_q <= {in_data.block_high, in_data.block_low};
		end else if (cmd.add_key) begin
			st_q <= st_q ^ round_key;
		end else if (cmd.round) begin
			st_q <= nxt;
		end
		if (cmd.load_out) begin
			res_q <= st_q;
		end
	end

	assign out_data.result_high = res_q[127:64];
	assign out_data.result_low  = res_q[63:0];

endmodule

@@ sv/aes_ctrl.sv @@
// aes_ctrl: sequencing state machine for key expansion, rounds and result handoff
// depends on aes_pkg

module aes_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_action,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              cfg_we,
	input  logic [1:0]        klen,
	output aes_pkg::aes_cmd_t cmd
);
	import aes_pkg::*;

	aes_state_t state_q, state_d;
	logic       dirty_q;
	logic [5:0] kidx_q;
	logic [3:0] rnd_q;
	logic [3:0] nr_q;
	logic       dec_q;
	logic       out_valid_q;
	logic       last_round;
	logic       out_free;

	assign last_round = rnd_q == nr_q;
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = dirty_q ? ST_EXPAND : ST_START;
			ST_EXPAND: if (kidx_q == {nr_q, 2'b11}) state_d = ST_START;
			ST_START:  state_d = ST_ADDK;
			ST_ADDK:   state_d = ST_RUN;
			ST_RUN:    if (last_round) state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.decrypt  = dec_q;
		cmd.kidx     = kidx_q;
		cmd.last     = last_round;
		unique case (state_q)
			ST_IDLE:   cmd.capture = in_valid;
			ST_EXPAND: cmd.kx_step = 1'b1;
			ST_START:  cmd.rd_row = dec_q ? nr_q : 4'd0;
			ST_ADDK: begin
				cmd.add_key = 1'b1;
				cmd.rd_row  = dec_q ? nr_q - 4'd1 : 4'd1;
			end
			ST_RUN: begin
				cmd.round = 1'b1;
				if (!last_round) cmd.rd_row = dec_q ? nr_q - rnd_q - 4'd1 : rnd_q + 4'd1;
			end
			ST_DONE:   cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dirty_q     <= 1'b1;
			kidx_q      <= '0;
			rnd_q       <= '0;
			nr_q        <= 4'd10;
			dec_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid) begin
				dec_q  <= in_action;
				nr_q   <= nr_of(klen);
				kidx_q <= '0;
			end else if (state_q == ST_EXPAND) begin
				kidx_q <= kidx_q + 6'd1;
			end
			if (state_q == ST_ADDK) begin
				rnd_q <= 4'd1;
			end else if (state_q == ST_RUN) begin
				rnd_q <= rnd_q + 4'd1;
			end
			if (cfg_we) begin
				dirty_q <= 1'b1;
			end else if (state_q == ST_EXPAND && state_d == ST_START) begin
				dirty_q <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	a_kidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXPAND |-> kidx_q < 6'(KEY_WORDS))
		else $error("key schedule index out of range");

	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> (rnd_q >= 4'd1 && rnd_q <= nr_q))
		else $error("round counter out of range");

	a_clean_after_expand: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXPAND && state_d == ST_START && !cfg_we) |=> !dirty_q)
		else $error("key schedule still marked stale after expansion");

	a_load_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result not handed to output register");

endmodule

@@ test/testbench.sv @@
// testbench: self-checking test of aes_block_cipher_unit, ecb encrypt and decrypt
// depends on aes_pkg and aes_block_cipher_unit; own cipher predictor, directed table then random

module testbench;
	import aes_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	aes_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	aes_out_t out_data;
	logic     cfg_valid;
	logic     cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	aes_block_cipher_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam int CYCLE_LIMIT = 400000;
	localparam logic ACT_ENC = 1'b0;
	localparam logic ACT_DEC = 1'b1;

	logic [1:0]  key_len_reg;
	logic [63:0] key_reg [4];
	logic [31:0] sched [60];
	aes_out_t    cipher_queue [$];
	int          fail_count;
	int          cycle_count;
	bit          calm;

	function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic logic [7:0] finv(input logic [7:0] x);
		logic [7:0] r;
		r = 8'h01;
		for (int i = 0; i < 254; i++) r = fmul(r, x);
		return r;
	endfunction

	logic [7:0] fwd_box [256];
	logic [7:0] inv_box [256];

	task automatic build_boxes();
		logic [7:0] b;
		for (int x = 0; x < 256; x++) begin
			b = finv(8'(x));
			fwd_box[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
				^ {b[3:0], b[7:4]} ^ 8'h63;
			inv_box[fwd_box[x]] = 8'(x);
		end
	endtask

	function automatic logic [31:0] box_word(input logic [31:0] w);
		return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
	endfunction

	function automatic int expand_schedule();
		int kl, nk, nr;
		logic [7:0]  rc;
		logic [31:0] t;
		logic [255:0] kbits;
		kl = (key_len_reg == 2'd3) ? 2 : int'(key_len_reg);
		nk = 4 + 2 * kl;
		nr = nk + 6;
		rc = 8'h01;
		kbits = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
		for (int i = 0; i < nk; i++) sched[i] = kbits[255 - 32 * i -: 32];
		for (int i = nk; i < 4 * (nr + 1); i++) begin
			t = sched[i - 1];
			if (i % nk == 0) begin
				t = box_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = fmul(rc, 8'h02);
			end else if (nk > 6 && i % nk == 4) begin
				t = box_word(t);
			end
			sched[i] = t ^ sched[i - nk];
		end
		return nr;
	endfunction

	function automatic aes_out_t cipher_block(input aes_in_t req);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] col [4];
		logic [7:0] mf [4];
		logic [7:0] mi [4];
		logic [127:0] blk;
		int nr, rd;
		aes_out_t res;
		mf = '{8'd2, 8'd3, 8'd1, 8'd1};
		mi = '{8'd14, 8'd11, 8'd13, 8'd9};
		nr = expand_schedule();
		blk = {req.block_high, req.block_low};
		for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
		for (int step = 0; step <= nr; step++) begin
			rd = req.action ? nr - step : step;
			if (step > 0) begin
				for (int i = 0; i < 16; i++)
					s[i] = req.action ? inv_box[s[i]] : fwd_box[s[i]];
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						t[4 * c + r] = s[4 * (req.action ? (c - r + 4) & 3 : (c + r) & 3) + r];
				s = t;
				if (!req.action && step < nr) begin
					for (int c = 0; c < 4; c++) begin
						for (int r = 0; r < 4; r++) begin
							col[r] = 8'h00;
							for (int k = 0; k < 4; k++)
								col[r] ^= fmul(s[4 * c + k], mf[(k - r + 4) & 3]);
						end
						for (int r = 0; r < 4; r++) s[4 * c + r] = col[r];
					end
				end
			end
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					s[4 * c + r] ^= sched[4 * rd + c][31 - 8 * r -: 8];
			if (req.action && step > 0 && step < nr) begin
				for (int c = 0; c < 4; c++) begin
					for (int r = 0; r < 4; r++) begin
						col[r] = 8'h00;
						for (int k = 0; k < 4; k++)
							col[r] ^= fmul(s[4 * c + k], mi[(k - r + 4) & 3]);
					end
					for (int r = 0; r < 4; r++) s[4 * c + r] = col[r];
				end
			end
		end
		for (int i = 0; i < 16; i++) blk[127 - 8 * i -: 8] = s[i];
		res.result_high = blk[127:64];
		res.result_low = blk[63:0];
		return res;
	endfunction

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (cipher_queue.size() == 0) begin
				$error("unexpected result %h", out_data);
				fail_count = fail_count + 1;
			end else begin
				if (out_data.result_high !== cipher_queue[0].result_high) begin
					$error("result_high expected %h actual %h",
						cipher_queue[0].result_high, out_data.result_high);
					fail_count = fail_count + 1;
				end
				if (out_data.result_low !== cipher_queue[0].result_low) begin
					$error("result_low expected %h actual %h",
						cipher_queue[0].result_low, out_data.result_low);
					fail_count = fail_count + 1;
				end
				void'(cipher_queue.pop_front());
			end
		end
		if (arst_n)
			out_ready <= calm || ($urandom_range(99) >= 27);
	end

	// leaves cfg_valid high; the caller drops it after its last write
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_KEY_LENGTH) key_len_reg = val[1:0];
		else if (idx <= CFG_KEY_WORD_3) key_reg[idx - 1] = val;
	endtask

	// typed expectation is used when given, else predictor
	task automatic send_request(input aes_in_t req, input bit typed, input aes_out_t want);
		while (!calm && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		cipher_queue.push_back(typed ? want : cipher_block(req));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (cipher_queue.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic load_key(input logic [1:0] kl, input logic [255:0] k);
		write_reg(CFG_KEY_LENGTH, {62'd0, kl});
		write_reg(CFG_KEY_WORD_0, k[255:192]);
		write_reg(CFG_KEY_WORD_1, k[191:128]);
		write_reg(CFG_KEY_WORD_2, k[127:64]);
		write_reg(CFG_KEY_WORD_3, k[63:0]);
		cfg_valid <= 1'b0;
	endtask

	typedef struct {
		logic [1:0]   kl;
		logic [255:0] key;
		aes_in_t      req;
		bit           typed;
		aes_out_t     want;
	} vector_t;

	vector_t vectors [$];

	initial begin
		aes_in_t  req;
		logic [255:0] k;
		logic [1:0] kl;
		logic [255:0] fips_key;
		fips_key = 256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f;
		clk = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		calm = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		key_len_reg = '0;
		for (int i = 0; i < 4; i++) key_reg[i] = '0;
		build_boxes();
		vectors = '{
			'{KEY_LEN_128, fips_key, '{ACT_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff},
				1, '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a}},
			'{KEY_LEN_128, fips_key, '{ACT_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
				1, '{64'h0011223344556677, 64'h8899aabbccddeeff}},
			'{KEY_LEN_192, fips_key, '{ACT_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff},
				1, '{64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191}},
			'{KEY_LEN_192, fips_key, '{ACT_DEC, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191},
				1, '{64'h0011223344556677, 64'h8899aabbccddeeff}},
			'{KEY_LEN_256, fips_key, '{ACT_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff},
				1, '{64'h8ea2b7ca516745bf, 64'heafc49904b496089}},
			'{KEY_LEN_256, fips_key, '{ACT_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089},
				1, '{64'h0011223344556677, 64'h8899aabbccddeeff}},
			'{2'd3, fips_key, '{ACT_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff},
				1, '{64'h8ea2b7ca516745bf, 64'heafc49904b496089}},
			'{KEY_LEN_128, '0, '{ACT_ENC, 64'h0, 64'h0}, 0, '0},
			'{KEY_LEN_128, '1, '{ACT_ENC, '1, '1}, 0, '0},
			'{KEY_LEN_128, '1, '{ACT_DEC, '1, '1}, 0, '0},
			'{KEY_LEN_192, '1, '{ACT_DEC, 64'h0, 64'h0}, 0, '0},
			'{KEY_LEN_256, '1, '{ACT_ENC, 64'h0, '1}, 0, '0},
			'{KEY_LEN_256, '0, '{ACT_DEC, '1, 64'h0}, 0, '0},
			'{KEY_LEN_128, {fips_key[255:128], ~fips_key[127:0]},
				'{ACT_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff},
				1, '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a}}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// all-zero key after reset
		send_request('{ACT_ENC, 64'h0, 64'h0}, 1, '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
		drain();
		write_reg(3'd5, '1);
		write_reg(3'd7, 64'h0123);
		cfg_valid <= 1'b0;
		send_request('{ACT_ENC, 64'h0, 64'h0}, 1, '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
		drain();
		foreach (vectors[i]) begin
			load_key(vectors[i].kl, vectors[i].key);
			send_request(vectors[i].req, vectors[i].typed, vectors[i].want);
			drain();
		end
		for (int phase = 0; phase < 12; phase++) begin
			kl = (phase % 4 == 3) ? 2'd3 : 2'(phase % 3);
			for (int w = 0; w < 8; w++) k[32 * w +: 32] = $urandom;
			load_key(kl, k);
			calm = (phase == 5);
			for (int n = 0; n < 50; n++) begin
				req.action = 1'($urandom_range(1));
				req.block_high = {$urandom, $urandom};
				req.block_low = {$urandom, $urandom};
				send_request(req, 0, '0);
			end
			drain();
		end
		if (fail_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule
